/* hw/rtl/bpa_pkg.sv */
package bpa_pkg;

  // default sizing
  localparam int NUM_OBJECTS_DEF = 4096;
  localparam int BUNDLE_SIZE_DEF = 128;
  localparam int CPU_COUNT_DEF   = 8;

  // fixed field widths of the channel words
  localparam int ACTION_W = 1;
  localparam int CPU_ID_W = 3;
  localparam int INDEX_W  = 12;
  localparam int STATUS_W = 3;

  // request codes
  localparam logic [ACTION_W-1:0] ACT_ALLOC = 1'b0;
  localparam logic [ACTION_W-1:0] ACT_FREE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_LOCAL   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_GLOBAL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FREED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DONATED = 3'd4;

  // controller states
  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_NL_RD,
    S_BD_RD,
    S_MK_RD,
    S_MK_WB,
    S_RESP
  } state_t;

endpackage

/* hw/rtl/bpa_if.sv */
interface bpa_in_if;
  logic                          valid;
  logic                          ready;
  logic [bpa_pkg::ACTION_W-1:0]  action;
  logic [bpa_pkg::CPU_ID_W-1:0]  cpu_id;
  logic [bpa_pkg::INDEX_W-1:0]   object_index;

  modport source (output valid, action, cpu_id, object_index, input ready);
  modport sink (input valid, action, cpu_id, object_index, output ready);
endinterface

interface bpa_out_if;
  logic                          valid;
  logic                          ready;
  logic [bpa_pkg::STATUS_W-1:0]  status;
  logic [bpa_pkg::INDEX_W-1:0]   granted_index;

  modport source (output valid, status, granted_index, input ready);
  modport sink (input valid, status, granted_index, output ready);
endinterface

/* hw/rtl/per_cpu_bundle_object_allocator.sv */
// paths: a plain free or out of objects goes straight to S_RESP; a local
//   pop reads the link memory first, a bundle take the bundle memory, and
//   a donating free reads, then cuts, the marker link; S_RESP holds while
//   the output register is busy; one request at a time, but a result may
//   wait in the output register while the next request is taken
// reset: a sweep rebuilds the bundle chains, no request is taken until it
//   ends; per-cpu lists start empty
module per_cpu_bundle_object_allocator #(
  parameter int NUM_OBJECTS = bpa_pkg::NUM_OBJECTS_DEF,
  parameter int BUNDLE_SIZE = bpa_pkg::BUNDLE_SIZE_DEF,
  parameter int CPU_COUNT   = bpa_pkg::CPU_COUNT_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  bpa_in_if.sink   in_ch,
  bpa_out_if.source out_ch
);

  localparam int AW = $clog2(NUM_OBJECTS);
  localparam int PW = $clog2(NUM_OBJECTS + 1);
  localparam int CI = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int CW = $clog2(2 * BUNDLE_SIZE + 1);
  localparam int IW = bpa_pkg::INDEX_W;
  localparam int SW = bpa_pkg::STATUS_W;
  localparam int IDW = bpa_pkg::CPU_ID_W;
  localparam logic [PW-1:0] Nil = PW'(NUM_OBJECTS);
  localparam logic [PW-1:0] GtInit = (NUM_OBJECTS / BUNDLE_SIZE > 0) ? '0 : Nil;

  bpa_pkg::state_t state_r, state_nxt;

  logic [PW-1:0] head_r   [CPU_COUNT];
  logic [PW-1:0] marker_r [CPU_COUNT];
  logic [CW-1:0] count_r  [CPU_COUNT];
  logic [PW-1:0] gt_r;
  logic [CI-1:0] cpu_r;
  logic [IW-1:0] grant_r;
  logic [SW-1:0] status_r;
  logic          out_valid_r;
  logic [IW-1:0] out_grant_r;
  logic [SW-1:0] out_status_r;

  // sweep
  logic          sw_active;
  logic [AW-1:0] sw_addr;
  logic [PW-1:0] sw_nl, sw_bl, sw_bn;

  // memories
  logic            nl_we, bd_we;
  logic [AW-1:0]   nl_addr, bd_addr;
  logic [PW-1:0]   nl_wdata, nl_rdata;
  logic [2*PW-1:0] bd_wdata, bd_rdata;

  // request decode
  logic          acc;
  logic [CI-1:0] cpu_sel;
  logic [PW-1:0] h, m, obj;
  logic          h_ok, m_ok, gt_ok, obj_ok, donate, slot_free;
  logic [CW-1:0] c_inc;

  bpa_sweep #(
    .NUM_OBJECTS(NUM_OBJECTS),
    .BUNDLE_SIZE(BUNDLE_SIZE)
  ) u_sweep (
    .clk(clk), .rst_n(rst_n), .active(sw_active), .addr(sw_addr),
    .nl_init(sw_nl), .bl_init(sw_bl), .bn_init(sw_bn)
  );

  bpa_ram #(.WIDTH(PW), .DEPTH(NUM_OBJECTS)) u_next_link (
    .clk(clk), .we(nl_we), .addr(nl_addr), .wdata(nl_wdata), .rdata(nl_rdata)
  );

  // bundle memory word: {second object, next bundle}
  bpa_ram #(.WIDTH(2 * PW), .DEPTH(NUM_OBJECTS)) u_bundle (
    .clk(clk), .we(bd_we), .addr(bd_addr), .wdata(bd_wdata), .rdata(bd_rdata)
  );

  // decode of the incoming word against per-cpu state
  always_comb begin
    acc     = in_ch.valid && in_ch.ready;
    // cpu id folded onto the cpu count by a small constant table
    cpu_sel = '0;
    for (int i = 0; i < 2 ** IDW; i++) begin
      if (in_ch.cpu_id == IDW'(i)) cpu_sel = CI'(i % CPU_COUNT);
    end
    h         = head_r[cpu_sel];
    m         = marker_r[cpu_sel];
    h_ok      = h < Nil;
    m_ok      = m < Nil;
    gt_ok     = gt_r < Nil;
    obj_ok    = 32'(in_ch.object_index) < NUM_OBJECTS;
    obj       = PW'(in_ch.object_index);
    c_inc     = count_r[cpu_sel] + CW'(1);
    donate    = obj_ok && (c_inc == CW'(2 * BUNDLE_SIZE));
    slot_free = !out_valid_r || out_ch.ready;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bpa_pkg::S_SWEEP: if (!sw_active) state_nxt = bpa_pkg::S_IDLE;
      bpa_pkg::S_IDLE: begin
        if (acc) begin
          if (in_ch.action == bpa_pkg::ACT_ALLOC) begin
            if (h_ok) state_nxt = bpa_pkg::S_NL_RD;
            else if (gt_ok) state_nxt = bpa_pkg::S_BD_RD;
            else state_nxt = bpa_pkg::S_RESP;
          end else if (donate && m_ok) begin
            state_nxt = bpa_pkg::S_MK_RD;
          end else begin
            state_nxt = bpa_pkg::S_RESP;
          end
        end
      end
      bpa_pkg::S_NL_RD: state_nxt = bpa_pkg::S_RESP;
      bpa_pkg::S_BD_RD: state_nxt = bpa_pkg::S_RESP;
      bpa_pkg::S_MK_RD: state_nxt = bpa_pkg::S_MK_WB;
      bpa_pkg::S_MK_WB: state_nxt = bpa_pkg::S_RESP;
      bpa_pkg::S_RESP: if (slot_free) state_nxt = bpa_pkg::S_IDLE;
      default: state_nxt = bpa_pkg::S_SWEEP;
    endcase
  end

  // memory port control
  always_comb begin
    in_ch.ready = state_r == bpa_pkg::S_IDLE;
    nl_we    = 1'b0;
    nl_addr  = marker_r[cpu_r][AW-1:0];
    nl_wdata = Nil;
    bd_we    = 1'b0;
    bd_addr  = gt_r[AW-1:0];
    bd_wdata = {h, gt_r};
    case (state_r)
      bpa_pkg::S_SWEEP: begin
        nl_we    = sw_active;
        nl_addr  = sw_addr;
        nl_wdata = sw_nl;
        bd_we    = sw_active;
        bd_addr  = sw_addr;
        bd_wdata = {sw_bl, sw_bn};
      end
      bpa_pkg::S_IDLE: begin
        if (in_ch.action == bpa_pkg::ACT_ALLOC) begin
          nl_addr = h[AW-1:0];
        end else begin
          nl_addr  = obj[AW-1:0];
          nl_wdata = h;
          nl_we    = acc && obj_ok;
          bd_addr  = obj[AW-1:0];
          bd_we    = acc && donate;
        end
      end
      bpa_pkg::S_MK_WB: nl_we = 1'b1;
      default: nl_we = 1'b0;
    endcase
  end

  // per-cpu list state, global stack top and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpa_pkg::S_SWEEP;
      gt_r        <= GtInit;
      cpu_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CPU_COUNT; i++) begin
        head_r[i]   <= Nil;
        marker_r[i] <= Nil;
        count_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      // output word register
      if (state_r == bpa_pkg::S_RESP && slot_free) begin
        out_valid_r  <= 1'b1;
        out_status_r <= status_r;
        out_grant_r  <= grant_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        bpa_pkg::S_IDLE: begin
          if (acc) begin
            cpu_r <= cpu_sel;
            if (in_ch.action == bpa_pkg::ACT_ALLOC) begin
              if (h_ok) begin
                grant_r  <= IW'(h);
                status_r <= bpa_pkg::ST_LOCAL;
                if (count_r[cpu_sel] != '0) count_r[cpu_sel] <= count_r[cpu_sel] - CW'(1);
              end else if (gt_ok) begin
                count_r[cpu_sel] <= '0;
                grant_r          <= IW'(gt_r);
                status_r         <= bpa_pkg::ST_GLOBAL;
              end else begin
                count_r[cpu_sel] <= '0;
                grant_r          <= '0;
                status_r         <= bpa_pkg::ST_EMPTY;
              end
            end else begin
              grant_r <= '0;
              if (donate) begin
                status_r         <= bpa_pkg::ST_DONATED;
                count_r[cpu_sel] <= CW'(BUNDLE_SIZE);
                gt_r             <= obj;
                head_r[cpu_sel]  <= m_ok ? obj : Nil;
              end else begin
                status_r <= bpa_pkg::ST_FREED;
                if (obj_ok) begin
                  head_r[cpu_sel]  <= obj;
                  count_r[cpu_sel] <= c_inc;
                  if (c_inc == CW'(BUNDLE_SIZE + 1)) marker_r[cpu_sel] <= obj;
                end
              end
            end
          end
        end
        bpa_pkg::S_NL_RD: head_r[cpu_r] <= nl_rdata;
        bpa_pkg::S_BD_RD: begin
          head_r[cpu_r]  <= bd_rdata[2*PW-1:PW];
          gt_r           <= bd_rdata[PW-1:0];
          count_r[cpu_r] <= CW'(BUNDLE_SIZE - 1);
        end
        bpa_pkg::S_MK_WB: head_r[cpu_r] <= nl_rdata;
        default: ;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.granted_index = out_grant_r;

  // no grant index on a miss or a free
  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != bpa_pkg::ST_LOCAL &&
    out_ch.status != bpa_pkg::ST_GLOBAL |-> out_ch.granted_index == '0)
    else $error("grant index set without a grant");

  // a list never holds a full double bundle between requests
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bpa_pkg::S_RESP |-> count_r[cpu_r] < CW'(2 * BUNDLE_SIZE))
    else $error("per-cpu count out of range");

  // no request taken during the init sweep
  a_sweep_block: assert property (@(posedge clk) disable iff (!rst_n)
    sw_active |-> !in_ch.ready)
    else $error("request accepted during sweep");

  // marker link is cut in the cycle after its read
  a_marker_wb: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bpa_pkg::S_MK_RD |=> state_r == bpa_pkg::S_MK_WB && nl_we)
    else $error("marker write-back missing");

endmodule

/* hw/rtl/bpa_ram.sv */
module bpa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/bpa_sweep.sv */
module bpa_sweep #(
  parameter int NUM_OBJECTS = bpa_pkg::NUM_OBJECTS_DEF,
  parameter int BUNDLE_SIZE = bpa_pkg::BUNDLE_SIZE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  output logic                           active,
  output logic [$clog2(NUM_OBJECTS)-1:0] addr,
  output logic [$clog2(NUM_OBJECTS+1)-1:0] nl_init,
  output logic [$clog2(NUM_OBJECTS+1)-1:0] bl_init,
  output logic [$clog2(NUM_OBJECTS+1)-1:0] bn_init
);

  localparam int AW    = $clog2(NUM_OBJECTS);
  localparam int PW    = $clog2(NUM_OBJECTS + 1);
  localparam int OW    = $clog2(BUNDLE_SIZE);
  localparam int Limit = (NUM_OBJECTS / BUNDLE_SIZE) * BUNDLE_SIZE;

  logic [PW-1:0] idx_r;
  logic [OW-1:0] off_r;
  logic          in_bundle;
  logic          is_head;

  // walk every entry once after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      off_r <= '0;
    end else if (active) begin
      idx_r <= idx_r + PW'(1);
      off_r <= (off_r == OW'(BUNDLE_SIZE - 1)) ? '0 : off_r + OW'(1);
    end
  end

  // initial links: bundles chained in index order
  always_comb begin
    in_bundle = 32'(idx_r) < Limit;
    is_head   = in_bundle && (off_r == '0);
    active    = idx_r != PW'(NUM_OBJECTS);
    addr      = idx_r[AW-1:0];
    nl_init   = (in_bundle && off_r != OW'(BUNDLE_SIZE - 1)) ? idx_r + PW'(1)
                                                              : PW'(NUM_OBJECTS);
    bl_init   = is_head ? idx_r + PW'(1) : PW'(NUM_OBJECTS);
    bn_init   = (is_head && (32'(idx_r) + BUNDLE_SIZE < Limit))
                ? idx_r + PW'(BUNDLE_SIZE) : PW'(NUM_OBJECTS);
  end

endmodule
